### rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/rci_pkg.sv
package rci_pkg;

	// field widths
	localparam int MZ_W   = 31;
	localparam int INT_W  = 32;
	localparam int HW_W   = 20;
	localparam int THR_W  = 32;
	localparam int SUM_W  = 48;
	localparam int TOT_W  = 50;
	localparam int IDX_W  = 32;

	// channel count
	localparam int MAX_CH       = 4;
	localparam int CHANNELS_DEF = 4;

	// stream word widths
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 280;

	// register file
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [HW_W-1:0] HW_RESET = HW_W'(104858);

	typedef enum logic [2:0] {
		REG_HALF_WIDTH = 3'd0,
		REG_MIN_INT    = 3'd1,
		REG_DISCARD    = 3'd2,
		REG_CENTER0    = 3'd3,
		REG_CENTER1    = 3'd4,
		REG_CENTER2    = 3'd5,
		REG_CENTER3    = 3'd6
	} reg_idx_t;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [MZ_W-1:0]  mz_t;

endpackage

### rtl/reporter_channel_integrator_core.sv
// Reporter channel integrator
// Input stream s_*: one centroided peak per word, tdata carries peak m/z
// (Q11.20 Da) and intensity, tlast marks the final peak of a spectrum.
// Output stream m_*: one feature word per kept spectrum with the four
// thresholded channel sums, their total and a running feature index; the
// zero-total flag travels in tuser.
// Configuration through an APB-style port: half width, threshold, discard
// flag and the four channel centres; the user writes them only while the
// block is idle; the block does not enforce it. Throughput: one peak per
// cycle unless an output stall backs up, set by the single accumulate stage.
// Stages: input register, window compare, accumulate, threshold, total.
// Reset clears the accumulators, the feature counter, all valid flags and
// loads the register defaults.
// When the receiver stalls, the feature word holds; peaks keep flowing until
// three more finished spectra wait behind it (threshold, sum and accumulate
// stages) and one more peak sits in the input register, after which s_tready
// drops until the waiting word is taken.
`include "assert_macros.svh"

module reporter_channel_integrator_core
	import rci_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// peak stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // peak_mz[30:0], peak_intensity[62:31]
	input  logic                  s_tlast,   // last_peak
	// feature stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// value_ch0[47:0], value_ch1[95:48], value_ch2[143:96], value_ch3[191:144],
	// total_value[241:192], feature_index[273:242]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser,   // zero_total
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	// configuration registers
	logic [HW_W-1:0]  half_width_q;
	logic [THR_W-1:0] min_int_q;
	logic             discard_q;
	mz_t              center_q [MAX_CH];
	reg_idx_t         reg_sel;
	logic             cfg_wr;

	// pipeline
	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	mz_t              mz_s1;
	logic [INT_W-1:0] int_s1, int_s2;
	logic             last_s1, last_s2;
	logic [MAX_CH-1:0] hit_s2;
	sum_t             acc_q  [MAX_CH];
	sum_t             next_acc [MAX_CH];
	sum_t             sum_s3 [MAX_CH];
	sum_t             val_s4 [MAX_CH];
	logic [MAX_CH-1:0] zero_s4;

	// output
	logic             out_valid_q;
	sum_t             out_val_q [MAX_CH];
	logic [TOT_W-1:0] out_total_q;
	logic             out_empty_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [IDX_W-1:0] feat_cnt_q;
	logic [TOT_W-1:0] total_c;

	// flow control
	logic out_free, drop_s4, take4, free4, take3, free3, take2, free2, take1, free1;

	// register access
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HW_RESET;
			min_int_q    <= '0;
			discard_q    <= 1'b0;
			for (int c = 0; c < MAX_CH; c++) begin
				center_q[c] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_HALF_WIDTH: half_width_q <= pwdata[HW_W-1:0];
				REG_MIN_INT:    min_int_q    <= pwdata[THR_W-1:0];
				REG_DISCARD:    discard_q    <= pwdata[0];
				REG_CENTER0:    center_q[0]  <= pwdata[MZ_W-1:0];
				REG_CENTER1:    center_q[1]  <= pwdata[MZ_W-1:0];
				REG_CENTER2:    center_q[2]  <= pwdata[MZ_W-1:0];
				REG_CENTER3:    center_q[3]  <= pwdata[MZ_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_HALF_WIDTH: prdata = DATA_W'(half_width_q);
			REG_MIN_INT:    prdata = DATA_W'(min_int_q);
			REG_DISCARD:    prdata = DATA_W'(discard_q);
			REG_CENTER0:    prdata = DATA_W'(center_q[0]);
			REG_CENTER1:    prdata = DATA_W'(center_q[1]);
			REG_CENTER2:    prdata = DATA_W'(center_q[2]);
			REG_CENTER3:    prdata = DATA_W'(center_q[3]);
			default:        prdata = '0;
		endcase
	end

	// stage advance; non-last peaks retire in the accumulate stage
	always_comb begin
		out_free = !out_valid_q || m_tready;
		drop_s4  = discard_q && (|zero_s4);
		take4    = valid_s4 && (drop_s4 || out_free);
		free4    = !valid_s4 || take4;
		take3    = valid_s3 && free4;
		free3    = !valid_s3 || take3;
		take2    = valid_s2 && (!last_s2 || free3);
		free2    = !valid_s2 || take2;
		take1    = valid_s1 && free2;
		free1    = !valid_s1 || take1;
	end

	assign s_tready = free1;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1)    valid_s1    <= s_tvalid;
			if (free2)    valid_s2    <= take1;
			if (free3)    valid_s3    <= take2 && last_s2;
			if (free4)    valid_s4    <= take3;
			if (out_free) out_valid_q <= take4 && !drop_s4;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (free1 && s_tvalid) begin
			mz_s1   <= s_tdata[MZ_W-1:0];
			int_s1  <= s_tdata[MZ_W+INT_W-1:MZ_W];
			last_s1 <= s_tlast;
		end
	end

	// word carried past the compare
	always_ff @(posedge clk) begin
		if (take1) begin
			int_s2  <= int_s1;
			last_s2 <= last_s1;
		end
	end

	// per-channel window compare, accumulate, threshold
	for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
		if (c < CHANNELS) begin : g_used
			logic [MZ_W:0] lo_side, hi_side, mz_ext, ctr_ext;
			logic [SUM_W:0] sum_full;

			// inclusive window, lower edge clamps at zero by construction
			always_comb begin
				mz_ext  = {1'b0, mz_s1};
				ctr_ext = {1'b0, center_q[c]};
				lo_side = mz_ext + (MZ_W+1)'(half_width_q);
				hi_side = ctr_ext + (MZ_W+1)'(half_width_q);
			end

			always_ff @(posedge clk) begin
				if (take1) begin
					hit_s2[c] <= (lo_side >= ctr_ext) && (mz_ext <= hi_side);
				end
			end

			// saturating add
			always_comb begin
				sum_full = {1'b0, acc_q[c]} + (SUM_W+1)'(int_s2);
				if (!hit_s2[c]) begin
					next_acc[c] = acc_q[c];
				end else if (sum_full[SUM_W]) begin
					next_acc[c] = '1;
				end else begin
					next_acc[c] = sum_full[SUM_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					acc_q[c] <= '0;
				end else if (take2) begin
					acc_q[c] <= last_s2 ? '0 : next_acc[c];
				end
			end

			always_ff @(posedge clk) begin
				if (take2 && last_s2) begin
					sum_s3[c] <= next_acc[c];
				end
			end

			// threshold
			always_ff @(posedge clk) begin
				if (take3) begin
					if (sum_s3[c] < SUM_W'(min_int_q)) begin
						val_s4[c]  <= '0;
						zero_s4[c] <= 1'b1;
					end else begin
						val_s4[c]  <= sum_s3[c];
						zero_s4[c] <= (sum_s3[c] == '0);
					end
				end
			end
		end else begin : g_unused
			// channel out of use: collects nothing, never counts as zero
			assign hit_s2[c]   = 1'b0;
			assign acc_q[c]    = '0;
			assign next_acc[c] = '0;
			assign sum_s3[c]   = '0;
			assign val_s4[c]   = '0;
			assign zero_s4[c]  = 1'b0;
		end
	end

	// feature total
	always_comb begin
		total_c = '0;
		for (int c = 0; c < MAX_CH; c++) begin
			total_c = total_c + TOT_W'(val_s4[c]);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (take4 && !drop_s4) begin
			for (int c = 0; c < MAX_CH; c++) begin
				out_val_q[c] <= val_s4[c];
			end
			out_total_q <= total_c;
			out_empty_q <= (total_c == '0);
			out_idx_q   <= feat_cnt_q;
		end
	end

	// feature counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_cnt_q <= '0;
		end else if (take4 && !drop_s4) begin
			feat_cnt_q <= feat_cnt_q + IDX_W'(1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_empty_q;
	assign m_tdata  = {
		(OUT_DATA_W - MAX_CH*SUM_W - TOT_W - IDX_W)'(0),
		out_idx_q, out_total_q,
		out_val_q[3], out_val_q[2], out_val_q[1], out_val_q[0]
	};

	// checks
	`ASSERT_IMPL(a_stall_from_out, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled without a waiting feature")
	`ASSERT_NEXT(a_acc_clear, clk, arst_n, take2 && last_s2, acc_q[0] == '0, "accumulator not cleared after last peak")
	`ASSERT_NEXT(a_cnt_step, clk, arst_n, take4 && !drop_s4, feat_cnt_q == $past(feat_cnt_q) + IDX_W'(1), "feature counter did not advance")
	`ASSERT_IMPL(a_empty_flag, clk, arst_n, m_tvalid, m_tuser == (out_total_q == '0), "empty flag disagrees with total")

endmodule

### tb/sv/reporter_channel_integrator_core_tb.sv
`timescale 1ns / 100ps

module reporter_channel_integrator_core_tb
	import rci_pkg::*;
();

	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_PEAKS    = 64;
	localparam int TOT_LSB       = MAX_CH * SUM_W;
	localparam int IDX_LSB       = TOT_LSB + TOT_W;
	// register index with no register behind it
	localparam logic [2:0] REG_NONE = 3'd7;
	localparam mz_t MZ_MAX = '1;
	localparam logic [INT_W-1:0] INT_MAX = '1;

	typedef enum logic {ROW_PEAK, ROW_CFG} row_kind_t;

	// one line of the directed plan: a peak word or a register write
	typedef struct packed {
		row_kind_t        kind;
		logic [2:0]       ridx;
		logic [31:0]      a;
		logic [31:0]      b;
		logic             last;
		logic             known;
		sum_t             ev;
	} row_t;

	typedef struct packed {
		logic [IDX_W-1:0]     idx;
		logic                 empty;
		logic [TOT_W-1:0]     total;
		sum_t [MAX_CH-1:0]    ch;
	} feature_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // peak_mz[30:0], peak_intensity[62:31]
	logic                  s_tlast;   // last_peak
	logic                  m_tvalid;
	logic                  m_tready;
	// value_ch0..3 [191:0], total_value[241:192], feature_index[273:242]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;   // zero_total
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	reporter_channel_integrator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// integrator copy: settings and running sums
	logic [HW_W-1:0]  half_w;
	logic [THR_W-1:0] min_int;
	logic             discard;
	mz_t              centre [MAX_CH];
	sum_t             acc [MAX_CH];
	logic [IDX_W-1:0] feat_count;

	feature_t feat_q [$];
	row_t     plan [$];

	bit no_idle;
	bit hold_req;
	int mismatches;
	int n_peaks;
	int n_features;
	int n_dropped;
	int n_writes;
	int idle_run;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic row_t peak_row(input mz_t mz, input logic [INT_W-1:0] inten,
			input logic last);
		row_t r;
		r = '0;
		r.kind = ROW_PEAK;
		r.a = 32'(mz);
		r.b = inten;
		r.last = last;
		return r;
	endfunction

	// closing peak of a spectrum whose channels all end at ev
	function automatic row_t known_row(input mz_t mz, input logic [INT_W-1:0] inten,
			input sum_t ev);
		row_t r;
		r = peak_row(mz, inten, 1'b1);
		r.known = 1'b1;
		r.ev = ev;
		return r;
	endfunction

	function automatic row_t reg_row(input logic [2:0] idx, input logic [31:0] value);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.ridx = idx;
		r.b = value;
		return r;
	endfunction

	// window sums per peak, threshold and discard at the closing peak
	function automatic bit integrate_peak(input mz_t mz, input logic [INT_W-1:0] inten,
			input logic last, output feature_t f);
		logic [SUM_W:0]   s;
		logic [32:0]      lo_sum;
		logic [32:0]      hi_edge;
		sum_t             v;
		logic [TOT_W-1:0] total;
		bit               any_zero;
		f = '0;
		total = '0;
		any_zero = 1'b0;
		for (int c = 0; c < MAX_CH; c++) begin
			lo_sum = {2'b00, mz} + {13'd0, half_w};
			hi_edge = {2'b00, centre[c]} + {13'd0, half_w};
			if (lo_sum >= {2'b00, centre[c]} && {2'b00, mz} <= hi_edge) begin
				s = {1'b0, acc[c]} + {17'd0, inten};
				acc[c] = s[SUM_W] ? '1 : s[SUM_W-1:0];
			end
		end
		if (!last)
			return 1'b0;
		for (int c = 0; c < MAX_CH; c++) begin
			v = acc[c];
			if (v < {16'd0, min_int})
				v = '0;
			if (v == '0)
				any_zero = 1'b1;
			f.ch[c] = v;
			total = total + {2'b00, v};
			acc[c] = '0;
		end
		if (discard && any_zero) begin
			n_dropped++;
			return 1'b0;
		end
		f.total = total;
		f.empty = (total == '0);
		f.idx = feat_count;
		feat_count++;
		return 1'b1;
	endfunction

	// offer one peak word, predict once it is taken
	task automatic send_peak(input mz_t mz, input logic [INT_W-1:0] inten, input logic last,
			input logic known, input sum_t ev);
		feature_t f;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {1'b0, inten, mz};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		n_peaks++;
		if (integrate_peak(mz, inten, last, f)) begin
			if (known) begin
				for (int c = 0; c < MAX_CH; c++)
					f.ch[c] = ev;
				f.total = {ev, 2'b00};
				f.empty = (ev == '0);
			end
			feat_q = {feat_q, f};
		end
	endtask

	// stop offering, let every feature word out and the pipeline empty
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		while (feat_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write: setup then access
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		n_writes++;
		case (idx)
			REG_HALF_WIDTH: half_w = value[HW_W-1:0];
			REG_MIN_INT:    min_int = value[THR_W-1:0];
			REG_DISCARD:    discard = value[0];
			REG_CENTER0, REG_CENTER1, REG_CENTER2, REG_CENTER3:
				centre[idx - 3'(REG_CENTER0)] = value[MZ_W-1:0];
			default: ;
		endcase
	endtask

	// random settings, then spectra of random length (one peak each under pressure) with peaks mostly around the centres
	task automatic random_phase(input int budget, input bit pressure);
		longint base;
		longint m;
		int     hw;
		int     len;
		int     got;
		int     c;
		logic [INT_W-1:0] inten;
		settle();
		case ($urandom_range(0, 4))
			0: hw = 1;
			1: hw = 524288;
			2: hw = 0;
			default: hw = $urandom_range(1, 524288);
		endcase
		write_reg(REG_HALF_WIDTH, 32'(hw));
		case ($urandom_range(0, 4))
			0: write_reg(REG_MIN_INT, 32'd0);
			1: write_reg(REG_MIN_INT, INT_MAX);
			2: write_reg(REG_MIN_INT, $urandom_range(0, 5000));
			default: write_reg(REG_MIN_INT, $urandom);
		endcase
		write_reg(REG_DISCARD, $urandom_range(0, 1));
		case ($urandom_range(0, 2))
			0: base = $urandom_range(0, 2000);
			1: base = longint'(MZ_MAX) - $urandom_range(0, 2000);
			default: base = $urandom & 32'h7fff_ffff;
		endcase
		for (int i = 0; i < MAX_CH; i++) begin
			if ($urandom_range(0, 4) == 0)
				m = $urandom & 32'h7fff_ffff;
			else
				m = base + $urandom_range(0, 3 * hw + 1);
			if (m > longint'(MZ_MAX))
				m = longint'(MZ_MAX);
			write_reg(3'(REG_CENTER0 + i), 32'(m));
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_NONE, $urandom);
		if (pressure)
			hold_req = 1'b1;
		got = 0;
		while (got < budget) begin
			len = pressure ? 1 : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) != 0) begin
					c = $urandom_range(0, MAX_CH - 1);
					m = longint'(centre[c]) + $urandom_range(0, 2 * hw + 4) - (hw + 2);
					if (m < 0)
						m = 0;
					if (m > longint'(MZ_MAX))
						m = longint'(MZ_MAX);
				end else begin
					m = $urandom & 32'h7fff_ffff;
				end
				case ($urandom_range(0, 5))
					0: inten = $urandom;
					1: inten = INT_MAX;
					2: inten = '0;
					default: inten = $urandom_range(1, 1000);
				endcase
				send_peak(mz_t'(m), inten, i == len - 1, 1'b0, '0);
			end
			got += len;
		end
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_tready = 1'b1;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// feature word check against the oldest prediction
	always @(posedge clk) begin
		feature_t want;
		bit       bad;
		if (arst_n && m_tvalid && m_tready) begin
			if (feat_q.size() == 0) begin
				if (mismatches < 10)
					$display("feature word with none predicted, index %0d",
						m_tdata[IDX_LSB +: IDX_W]);
				mismatches++;
			end else begin
				want = feat_q.pop_front();
				bad = 1'b0;
				for (int c = 0; c < MAX_CH; c++) begin
					if (m_tdata[c*SUM_W +: SUM_W] !== want.ch[c]) begin
						bad = 1'b1;
						if (mismatches < 10)
							$display("feature %0d ch%0d: want %h got %h", want.idx, c,
								want.ch[c], m_tdata[c*SUM_W +: SUM_W]);
					end
				end
				if (m_tdata[TOT_LSB +: TOT_W] !== want.total) begin
					bad = 1'b1;
					if (mismatches < 10)
						$display("feature %0d total: want %h got %h", want.idx,
							want.total, m_tdata[TOT_LSB +: TOT_W]);
				end
				if (m_tuser !== want.empty) begin
					bad = 1'b1;
					if (mismatches < 10)
						$display("feature %0d zero_total: want %b got %b", want.idx,
							want.empty, m_tuser);
				end
				if (m_tdata[IDX_LSB +: IDX_W] !== want.idx) begin
					bad = 1'b1;
					if (mismatches < 10)
						$display("feature index: want %0d got %0d", want.idx,
							m_tdata[IDX_LSB +: IDX_W]);
				end
				if (bad)
					mismatches++;
				n_features++;
			end
		end
	end

	// watchdog on cycles with no word or write taken
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			idle_run <= 0;
		end else if (idle_run == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		half_w = HW_RESET;
		min_int = '0;
		discard = 1'b0;
		for (int c = 0; c < MAX_CH; c++) begin
			centre[c] = '0;
			acc[c] = '0;
		end
		feat_count = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		plan = '{
			// reset settings: all centres at zero, lower edge clamped
			known_row(31'd0, 32'd5, 48'd5),
			known_row(MZ_MAX, INT_MAX, 48'd0),
			// touching and overlapping windows, edges inclusive
			reg_row(REG_HALF_WIDTH, 32'd1000),
			reg_row(REG_CENTER0, 32'd1000),
			reg_row(REG_CENTER1, 32'd3000),
			reg_row(REG_CENTER2, 32'd5000),
			reg_row(REG_CENTER3, 32'd3500),
			peak_row(31'd0, 32'd7, 1'b0),
			peak_row(31'd2000, 32'd1, 1'b0),
			peak_row(31'd3000, 32'd10, 1'b0),
			peak_row(31'd4500, 32'd100, 1'b0),
			peak_row(31'd4501, 32'd1000, 1'b0),
			peak_row(31'd1500, 32'd2, 1'b1),
			// threshold with discard: two channels short, spectrum dropped
			reg_row(REG_MIN_INT, 32'd50),
			reg_row(REG_DISCARD, 32'd1),
			peak_row(31'd1000, 32'd60, 1'b0),
			peak_row(31'd5000, 32'd60, 1'b0),
			peak_row(31'd2200, 32'd49, 1'b1),
			// every channel over threshold, kept
			peak_row(31'd1000, 32'd60, 1'b0),
			peak_row(31'd3000, 32'd60, 1'b0),
			peak_row(31'd5000, 32'd60, 1'b1),
			// highest threshold clears everything
			reg_row(REG_DISCARD, 32'd0),
			reg_row(REG_MIN_INT, INT_MAX),
			known_row(31'd1000, 32'd10, 48'd0),
			// zero half width: only the exact centre counts
			reg_row(REG_MIN_INT, 32'd0),
			reg_row(REG_HALF_WIDTH, 32'd0),
			reg_row(REG_CENTER0, 32'd7777),
			reg_row(REG_CENTER1, 32'd7777),
			reg_row(REG_CENTER2, 32'd7777),
			reg_row(REG_CENTER3, 32'd7777),
			peak_row(31'd7776, 32'd1, 1'b0),
			peak_row(31'd7778, 32'd5, 1'b0),
			known_row(31'd7777, 32'd3, 48'd3),
			// widest window at the top of the m/z range, no wraparound
			reg_row(REG_HALF_WIDTH, 32'd524288),
			reg_row(REG_CENTER0, 32'(MZ_MAX)),
			reg_row(REG_CENTER1, 32'(MZ_MAX)),
			reg_row(REG_CENTER2, 32'(MZ_MAX)),
			reg_row(REG_CENTER3, 32'(MZ_MAX)),
			reg_row(REG_NONE, 32'd0),
			peak_row(MZ_MAX - 31'd524289, 32'd4, 1'b0),
			peak_row(MZ_MAX - 31'd524288, 32'd2, 1'b0),
			known_row(MZ_MAX, 32'd1, 48'd3)
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].ridx, plan[i].b);
			end else begin
				send_peak(mz_t'(plan[i].a), plan[i].b, plan[i].last, plan[i].known,
					plan[i].ev);
			end
		end

		// long spectrum of full-scale peaks: large sums, one channel stays small
		settle();
		write_reg(REG_HALF_WIDTH, 32'd16);
		write_reg(REG_CENTER0, 32'd100);
		write_reg(REG_CENTER1, 32'd100);
		write_reg(REG_CENTER2, 32'd100);
		write_reg(REG_CENTER3, 32'd5000);
		for (int i = 0; i < LONG_PEAKS; i++) begin
			if (i == LONG_PEAKS - 1)
				send_peak(31'd5000, 32'd1, 1'b1, 1'b0, '0);
			else
				send_peak(31'd100, INT_MAX, 1'b0, 1'b0, '0);
		end

		// random phases: second one under a long output hold, last one without gaps
		for (int p = 0; p < 6; p++) begin
			no_idle = (p == 5);
			random_phase(80, p == 1);
		end
		settle();

		$display("peaks %0d, features checked %0d, spectra dropped %0d, register writes %0d",
			n_peaks, n_features, n_dropped, n_writes);
		$display("window edges and overlap, zero and widest windows, large sums, threshold, "
			, "discard and a long output hold were exercised");
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatching feature words", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
